/* src/sha256_byte_stream_hasher_top_macros.svh */
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define SBSH_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define SBSH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sbsh_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Widths, sequencer states, round constants and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sbsh_pkg;

	localparam int IN_TDATA_W  = 8;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 256;
	localparam int BLOCK_W     = 512;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	// first byte position of the length field inside a block
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LAST_RND = 6'd63;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD
	} state_t;

	typedef logic [31:0] word_t;

	localparam word_t INIT_WORDS [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t ror(input word_t v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic word_t big_sig0(input word_t x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic word_t small_sig0(input word_t x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t choose(input word_t e, input word_t f, input word_t g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic word_t majority(input word_t a, input word_t b, input word_t c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

/* src/sha256_byte_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream with SHA-256 and emits the 256-bit digest per message.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the hasher is idle and shifted into a
// 512-bit block window. Each full 64-byte block drops tready for its
// 64 rounds through the single round unit (one round per cycle, schedule
// word computed in the same window) and for a fold of the working words
// into the chaining value. On the item with tlast, padding bytes (0x80, zeros,
// 64-bit bit length) go through the same byte path one per cycle in the
// padding state; the length takes an extra block when the marker lands at
// byte position 56 or later. The digest waits in an output register; the
// next message may start while it waits, and only a second digest stalls.

`include "sha256_byte_stream_hasher_top_macros.svh"

module sha256_byte_stream_hasher_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [sbsh_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] msg_byte
	input  logic [sbsh_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // [0] byte_present
	input  logic                             s_axis_tlast,  // end_of_message
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [63:0] digest_part0, [127:64] digest_part1,
	// [191:128] digest_part2, [255:192] digest_part3
	output logic [sbsh_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import sbsh_pkg::*;

	state_t                  state_q, state_d;
	logic [5:0]              fill_q;
	logic [5:0]              round_q;
	logic [63:0]             total_q;
	logic                    pad_q;
	logic                    first_q;
	logic                    len_blk_q;
	logic                    m_valid_q;
	logic [BLOCK_W-1:0]      win_q;
	word_t                   chain_q [8];
	word_t                   work_q [8];
	logic [OUT_TDATA_W-1:0]  digest_q;

	logic                    in_fire;
	logic                    byte_wr;
	logic [7:0]              byte_val;
	logic [7:0]              pad_val;
	logic [63:0]             bit_len;
	logic                    blk_full;
	logic                    fold_final;
	logic                    fold_go;
	word_t                   w_cur;
	word_t                   w_new;
	word_t                   t1;
	word_t                   t2;
	word_t                   sum [8];

	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// Padding byte: marker first, length bytes in the tail of the final block
	assign bit_len = {total_q[60:0], 3'b000};
	always_comb begin
		if (first_q) begin
			pad_val = PAD_BYTE;
		end else if (len_blk_q && (fill_q >= LEN_POS)) begin
			pad_val = bit_len[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_val = 8'h00;
		end
	end

	assign byte_wr  = (in_fire & s_axis_tuser[0]) | (state_q == ST_PAD);
	assign byte_val = (state_q == ST_PAD) ? pad_val : s_axis_tdata;
	assign blk_full = byte_wr & (fill_q == LAST_POS);

	assign fold_final = (state_q == ST_FOLD) & pad_q & len_blk_q;
	assign fold_go    = (state_q == ST_FOLD) & (~fold_final | ~m_valid_q | m_axis_tready);

	// Round unit and message schedule
	assign w_cur = win_q[BLOCK_W-1 -: 32];
	assign w_new = small_sig1(win_q[63:32]) + win_q[223:192]
		+ small_sig0(win_q[479:448]) + win_q[511:480];
	assign t1 = work_q[7] + big_sig1(work_q[4]) + choose(work_q[4], work_q[5], work_q[6])
		+ ROUND_K[round_q] + w_cur;
	assign t2 = big_sig0(work_q[0]) + majority(work_q[0], work_q[1], work_q[2]);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sum[i] = chain_q[i] + work_q[i];
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (blk_full) begin
						state_d = ST_ROUND;
					end else if (s_axis_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (blk_full) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_q == LAST_RND) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (fold_go) begin
					state_d = (pad_q && !fold_final) ? ST_PAD : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters, flags and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			round_q   <= '0;
			total_q   <= '0;
			pad_q     <= 1'b0;
			first_q   <= 1'b0;
			len_blk_q <= 1'b0;
			m_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_WORDS[i];
			end
		end else begin
			if (byte_wr) begin
				fill_q <= fill_q + 6'd1;
			end
			if (in_fire && s_axis_tuser[0]) begin
				total_q <= total_q + 64'd1;
			end
			if (in_fire && s_axis_tlast) begin
				pad_q   <= 1'b1;
				first_q <= 1'b1;
			end
			// marker position decides whether the length fits this block
			if (state_q == ST_PAD && first_q) begin
				first_q   <= 1'b0;
				len_blk_q <= (fill_q < LEN_POS);
			end
			if (state_q == ST_ROUND) begin
				round_q <= round_q + 6'd1;
			end
			if (m_valid_q && m_axis_tready && !(fold_go && fold_final)) begin
				m_valid_q <= 1'b0;
			end
			if (fold_go) begin
				if (fold_final) begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= INIT_WORDS[i];
					end
					total_q   <= '0;
					fill_q    <= '0;
					pad_q     <= 1'b0;
					len_blk_q <= 1'b0;
					m_valid_q <= 1'b1;
				end else begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= sum[i];
					end
					if (pad_q) begin
						len_blk_q <= 1'b1;
					end
				end
			end
		end
	end

	// Block window, working words and digest register
	always_ff @(posedge clk) begin
		if (byte_wr) begin
			win_q <= {win_q[BLOCK_W-9:0], byte_val};
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[BLOCK_W-33:0], w_new};
		end
		if (blk_full) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
		if (fold_go && fold_final) begin
			digest_q <= {sum[6], sum[7], sum[4], sum[5], sum[2], sum[3], sum[0], sum[1]};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = digest_q;

	// Checks
	`SBSH_ASSERT_SAME(a_round_idle, state_q != ST_ROUND, round_q == 6'd0, "round count off outside rounds")
	`SBSH_ASSERT_NEXT(a_full_starts, in_fire && s_axis_tuser[0] && fill_q == LAST_POS, state_q == ST_ROUND && fill_q == 6'd0, "full block did not start rounds")
	`SBSH_ASSERT_NEXT(a_final_resets, fold_go && fold_final, m_valid_q && total_q == 64'd0 && chain_q[0] == INIT_WORDS[0] && state_q == ST_IDLE, "digest not issued with state reset")

endmodule
